/* sv/napt_pkg.sv */
// Package for the address and port translation table: payload structs,
// operation and status codes, table geometry. No dependencies.
`timescale 1ns / 1ps
package napt_pkg;
    localparam int RULE_SLOTS = 1024;
    localparam int SLOT_W = $clog2(RULE_SLOTS);
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [1:0] {
        OP_OUTBOUND = 2'd0,
        OP_INBOUND = 2'd1,
        OP_SWEEP = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_TRANSLATED = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_FULL = 2'd2,
        ST_SWEEP_DONE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_PUBLIC_ADDRESS = 2'd0,
        CFG_IDLE_TIMEOUT = 2'd1,
        CFG_PORT_BASE = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_SCAN_LAST,
        S_INB_READ,
        S_INB_CHECK,
        S_SWEEP,
        S_SWEEP_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0] protocol;
        logic [31:0] now;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic [31:0] out_source_address;
        logic [31:0] out_dest_address;
        logic [15:0] out_source_port;
        logic [15:0] out_dest_port;
        logic [9:0] slot_index;
        logic new_rule;
        logic [10:0] freed_count;
    } t_result;

    typedef struct packed {
        logic [31:0] public_address;
        logic [31:0] idle_timeout;
        logic [15:0] port_base;
    } t_cfg;

    // Queue handshake between front and back.
    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_qctl;
endpackage

/* sv/napt_connection_table_unit.sv */
// Top level of the address and port translation table: configuration
// registers, request queue and table engine. Depends on napt_pkg.
`timescale 1ns / 1ps
// Usage: drive i_req and raise start; the request is taken at a clock edge
// where busy is low. Operation three is taken and dropped with no result.
// Each result shows on o_result for one cycle with o_done high; the receiver
// cannot stall it. Configuration is written through i_cfg_we, i_cfg_index and
// i_cfg_data, with no wait, while the block is idle.
// Timing is set by the table engine, which reads one slot per cycle from the
// rule memory: an inbound lookup reads only the candidate slot, an outbound
// lookup scans the slots until a hit or the last slot, and a sweep reads every
// slot. A two-entry queue takes new requests while the engine works.
// Reset restores the configuration defaults and starts a clearing pass that
// marks every slot free; the queue may take two requests meanwhile, and the
// engine serves them once the pass ends.
module napt_connection_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  napt_pkg::t_request i_req,
    output logic               o_done,
    output napt_pkg::t_result  o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    napt_pkg::t_cfg r_cfg;
    napt_pkg::t_request w_req;
    napt_pkg::t_qctl w_qctl;
    logic w_valid, w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.public_address <= 32'hbcbcbcbc;
            r_cfg.idle_timeout <= 32'd30;
            r_cfg.port_base <= 16'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                napt_pkg::CFG_PUBLIC_ADDRESS: r_cfg.public_address <= i_cfg_data;
                napt_pkg::CFG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_cfg_data;
                napt_pkg::CFG_PORT_BASE: r_cfg.port_base <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    napt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_req(i_req), .i_pop(w_pop), .o_valid(w_valid), .o_req(w_req),
        .o_qctl(w_qctl)
    );

    napt_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(w_valid),
        .i_req(w_req), .o_pop(w_pop), .o_done(o_done), .o_result(o_result)
    );

    // The engine never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qctl.empty) else $error("pop from empty queue");
    // A full queue never takes a push.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qctl.full |-> !w_qctl.push) else $error("queue overflow");
    // Results are single-cycle strobes.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
endmodule

/* sv/napt_front.sv */
// Front end: takes requests, drops unused operations, and holds a short
// request queue for the table engine. Depends on napt_pkg.
`timescale 1ns / 1ps
module napt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  napt_pkg::t_request i_req,
    input  logic              i_pop,
    output logic              o_valid,
    output napt_pkg::t_request o_req,
    output napt_pkg::t_qctl   o_qctl
);
    napt_pkg::t_request r_mem [napt_pkg::QUEUE_DEPTH];
    logic [napt_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [napt_pkg::QPTR_W:0] r_cnt, n_cnt;
    napt_pkg::t_qctl q;

    // Operation three does nothing, so it never enters the queue.
    always_comb begin
        q.full = (r_cnt == (napt_pkg::QPTR_W+1)'(napt_pkg::QUEUE_DEPTH));
        q.empty = (r_cnt == '0);
        q.push = i_start && !q.full &&
                 (i_req.operation != napt_pkg::OP_NONE);
        q.pop = i_pop && !q.empty;
        n_cnt = r_cnt + (napt_pkg::QPTR_W+1)'(q.push) - (napt_pkg::QPTR_W+1)'(q.pop);
    end

    assign o_busy = q.full;
    assign o_valid = !q.empty;
    assign o_req = r_mem[r_rp];
    assign o_qctl = q;

    // Queue storage and pointers.
    always_ff @(posedge i_clk) begin
        if (q.push) begin
            r_mem[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (q.push) r_wp <= r_wp + 1'b1;
            if (q.pop) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end
endmodule

/* sv/napt_engine.sv */
// Back end: walks the rule table in memory, one slot a cycle, to serve
// lookups, rule creation and idle sweeps. Depends on napt_pkg.
`timescale 1ns / 1ps
module napt_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  napt_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  napt_pkg::t_request i_req,
    output logic              o_pop,
    output logic              o_done,
    output napt_pkg::t_result o_result
);
    localparam int SW = napt_pkg::SLOT_W;
    localparam int RW = 32 + 16 + 32 + 16 + 8;

    // Rule memory, read one address a cycle with registered data.
    logic [RW-1:0] r_rule [napt_pkg::RULE_SLOTS];
    logic [31:0] r_seen [napt_pkg::RULE_SLOTS];
    logic r_vld [napt_pkg::RULE_SLOTS];

    napt_pkg::t_state r_state, n_state;
    napt_pkg::t_request r_req;
    logic [SW-1:0] r_idx, n_idx, r_ridx;
    logic [RW-1:0] r_rd;
    logic [31:0] r_rd_seen;
    logic r_rd_vld;
    logic r_have_free;
    logic [SW-1:0] r_free;
    logic r_hit;
    logic [SW-1:0] r_hit_idx;
    logic [napt_pkg::CNT_W-1:0] r_freed;
    logic r_rd_en;
    napt_pkg::t_result r_res;
    logic r_done;

    logic [RW-1:0] w_key;
    logic [15:0] w_cand;
    logic w_cand_ok;
    logic w_match, w_idle;
    logic w_first;

    // Outbound key and inbound candidate slot.
    assign w_key = {r_req.source_address, r_req.source_port, r_req.dest_address,
                    r_req.dest_port, r_req.protocol};
    assign w_cand = r_req.dest_port - i_cfg.port_base;
    assign w_cand_ok = (32'(w_cand) < 32'(napt_pkg::RULE_SLOTS));
    assign w_match = r_rd_vld && (r_rd == w_key);
    assign w_idle = r_rd_vld && ((r_req.now - r_rd_seen) >= i_cfg.idle_timeout);
    assign w_first = (r_state == napt_pkg::S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        unique case (r_state)
            napt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    unique case (i_req.operation)
                        napt_pkg::OP_OUTBOUND: n_state = napt_pkg::S_SCAN;
                        napt_pkg::OP_INBOUND: n_state = napt_pkg::S_INB_READ;
                        default: n_state = napt_pkg::S_SWEEP;
                    endcase
                end
            end
            napt_pkg::S_CLEAR: begin
                if (r_idx == SW'(napt_pkg::RULE_SLOTS - 1)) begin
                    n_state = napt_pkg::S_IDLE;
                    n_idx = '0;
                end else n_idx = r_idx + 1'b1;
            end
            napt_pkg::S_SCAN: begin
                if (r_rd_en && w_match) n_state = napt_pkg::S_DONE;
                else if (r_idx == SW'(napt_pkg::RULE_SLOTS - 1))
                    n_state = napt_pkg::S_SCAN_LAST;
                else n_idx = r_idx + 1'b1;
            end
            napt_pkg::S_SCAN_LAST: n_state = napt_pkg::S_DONE;
            napt_pkg::S_INB_READ: n_state = napt_pkg::S_INB_CHECK;
            napt_pkg::S_INB_CHECK: n_state = napt_pkg::S_DONE;
            napt_pkg::S_SWEEP: begin
                if (r_idx == SW'(napt_pkg::RULE_SLOTS - 1))
                    n_state = napt_pkg::S_SWEEP_LAST;
                else n_idx = r_idx + 1'b1;
            end
            napt_pkg::S_SWEEP_LAST: n_state = napt_pkg::S_DONE;
            napt_pkg::S_DONE: n_state = napt_pkg::S_IDLE;
            default: n_state = napt_pkg::S_IDLE;
        endcase
    end

    // Outputs toward the queue and the result port.
    always_comb begin
        o_pop = w_first && i_valid;
        o_done = r_done;
        o_result = r_res;
    end

    always_ff @(posedge i_clk) begin
        // Registered table read; the inbound read uses the candidate slot.
        // The inbound rule data is held through the check for the result.
        r_rd_en <= (r_state == napt_pkg::S_SCAN) || (r_state == napt_pkg::S_SWEEP) ||
                   (r_state == napt_pkg::S_INB_READ);
        r_ridx <= (r_state == napt_pkg::S_INB_READ) ? w_cand[SW-1:0] : r_idx;
        if (r_state != napt_pkg::S_INB_CHECK) begin
            r_rd <= r_rule[(r_state == napt_pkg::S_INB_READ) ? w_cand[SW-1:0] : r_idx];
        end
        r_rd_seen <= r_seen[r_idx];
        r_rd_vld <= r_vld[(r_state == napt_pkg::S_INB_READ) ? w_cand[SW-1:0] : r_idx]
                    && ((r_state != napt_pkg::S_INB_READ) || w_cand_ok);
        r_done <= 1'b0;

        // Clearing pass after reset: one slot marked free per cycle.
        if (r_state == napt_pkg::S_CLEAR) begin
            r_vld[r_idx] <= 1'b0;
        end

        if (w_first && i_valid) begin
            r_req <= i_req;
            r_have_free <= 1'b0;
            r_hit <= 1'b0;
            r_freed <= '0;
        end

        // Outbound scan: first hit wins, lowest free slot remembered.
        if ((r_state == napt_pkg::S_SCAN || r_state == napt_pkg::S_SCAN_LAST)
            && r_rd_en && !r_hit) begin
            if (w_match) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_ridx;
            end else if (!r_rd_vld && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free <= r_ridx;
            end
        end

        // Inbound check on the candidate slot.
        if (r_state == napt_pkg::S_INB_CHECK) begin
            if (r_rd_vld && r_req.dest_address == i_cfg.public_address &&
                r_rd[RW-49:0] == {r_req.source_address, r_req.source_port,
                                  r_req.protocol}) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_ridx;
            end
        end

        // Sweep: free idle slots as their data comes back.
        if ((r_state == napt_pkg::S_SWEEP || r_state == napt_pkg::S_SWEEP_LAST)
            && r_rd_en && w_idle) begin
            r_vld[r_ridx] <= 1'b0;
            r_freed <= r_freed + 1'b1;
        end

        // Finish: write back and build the result.
        if (r_state == napt_pkg::S_DONE) begin
            r_done <= 1'b1;
            r_res <= '0;
            unique case (r_req.operation)
                napt_pkg::OP_OUTBOUND: begin
                    if (r_hit || r_have_free) begin
                        r_res.status <= napt_pkg::ST_TRANSLATED;
                        r_res.out_source_address <= i_cfg.public_address;
                        r_res.out_dest_address <= r_req.dest_address;
                        r_res.out_source_port <= i_cfg.port_base +
                            16'(r_hit ? r_hit_idx : r_free);
                        r_res.out_dest_port <= r_req.dest_port;
                        r_res.slot_index <= 10'(r_hit ? r_hit_idx : r_free);
                        r_res.new_rule <= !r_hit;
                        r_seen[r_hit ? r_hit_idx : r_free] <= r_req.now;
                        if (!r_hit) begin
                            r_rule[r_free] <= w_key;
                            r_vld[r_free] <= 1'b1;
                        end
                    end else begin
                        r_res.status <= napt_pkg::ST_FULL;
                        r_res.out_source_address <= r_req.source_address;
                        r_res.out_dest_address <= r_req.dest_address;
                        r_res.out_source_port <= r_req.source_port;
                        r_res.out_dest_port <= r_req.dest_port;
                    end
                end
                napt_pkg::OP_INBOUND: begin
                    r_res.out_source_address <= r_req.source_address;
                    r_res.out_source_port <= r_req.source_port;
                    if (r_hit) begin
                        r_res.status <= napt_pkg::ST_TRANSLATED;
                        r_res.out_dest_address <= r_rd[RW-1:RW-32];
                        r_res.out_dest_port <= r_rd[RW-33:RW-48];
                        r_res.slot_index <= 10'(r_hit_idx);
                        r_seen[r_hit_idx] <= r_req.now;
                    end else begin
                        r_res.status <= napt_pkg::ST_NO_MATCH;
                        r_res.out_dest_address <= r_req.dest_address;
                        r_res.out_dest_port <= r_req.dest_port;
                    end
                end
                default: begin
                    r_res.status <= napt_pkg::ST_SWEEP_DONE;
                    r_res.freed_count <= 11'(r_freed);
                end
            endcase
        end

        if (!i_rst_n) begin
            r_state <= napt_pkg::S_CLEAR;
            r_idx <= '0;
            r_done <= 1'b0;
            r_rd_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end
endmodule
